FILE: rtl/upd_pkg.sv
package upd_pkg;

  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChSpace = 8'h20;

  localparam int unsigned QueueDepthDefault = 4;

  localparam int unsigned RecBytes = 3;

  // decoded bytes produced by one input beat, oldest in slot 0
  typedef struct packed {
    logic [1:0]                cnt;
    logic [RecBytes-1:0][7:0]  bytes;
    logic                      last;
  } upd_rec_t;

endpackage

FILE: rtl/upd_front.sv
module upd_front import upd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  logic [7:0] in_byte_i,
  input  logic     in_last_i,
  output logic     rec_push_o,
  output upd_rec_t rec_o
);

  typedef enum logic [1:0] {
    PhIdle  = 2'd0,
    PhPct   = 2'd1,
    PhDigit = 2'd2
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] held_q, held_d;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
    return v[3:0];
  endfunction

  logic       starts_esc;
  logic [7:0] plain_byte;
  logic       b_hex;

  assign starts_esc = (in_byte_i == ChPct) && !in_last_i;
  assign plain_byte = (in_byte_i == ChPlus) ? ChSpace : in_byte_i;
  assign b_hex      = is_hex(in_byte_i);

  always_comb begin
    phase_d   = phase_q;
    held_d    = held_q;
    rec_o     = '0;
    rec_o.last = in_last_i;
    case (phase_q)
      PhPct: begin
        if (b_hex && !in_last_i) begin
          held_d  = in_byte_i;
          phase_d = PhDigit;
        end else begin
          rec_o.bytes[0] = ChPct;
          if (starts_esc) begin
            rec_o.cnt = 2'd1;
            phase_d   = PhPct;
          end else begin
            rec_o.cnt      = 2'd2;
            rec_o.bytes[1] = plain_byte;
            phase_d        = PhIdle;
          end
        end
      end
      PhDigit: begin
        if (b_hex) begin
          rec_o.cnt      = 2'd1;
          rec_o.bytes[0] = {hex_val(held_q), hex_val(in_byte_i)};
          phase_d        = PhIdle;
        end else begin
          rec_o.bytes[0] = ChPct;
          rec_o.bytes[1] = held_q;
          if (starts_esc) begin
            rec_o.cnt = 2'd2;
            phase_d   = PhPct;
          end else begin
            rec_o.cnt      = 2'd3;
            rec_o.bytes[2] = plain_byte;
            phase_d        = PhIdle;
          end
        end
      end
      default: begin
        if (starts_esc) begin
          phase_d = PhPct;
        end else begin
          rec_o.cnt      = 2'd1;
          rec_o.bytes[0] = plain_byte;
          phase_d        = PhIdle;
        end
      end
    endcase
  end

  assign rec_push_o = accept_i && (rec_o.cnt != 2'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      held_q  <= 8'h00;
    end else if (accept_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

FILE: rtl/upd_queue.sv
module upd_queue import upd_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  upd_rec_t wdata_i,
  input  logic     pop_i,
  output upd_rec_t rdata_o,
  output logic     full_o,
  output logic     empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrMax = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  upd_rec_t            mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]     cnt_q;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrMax) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrMax) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/upd_back.sv
module upd_back import upd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rec_valid_i,
  input  upd_rec_t   rec_i,
  output logic       rec_pop_o,
  input  logic       pop_i,
  output logic       empty_o,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  logic [1:0] idx_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic       load;
  logic       final_slot;

  assign load       = rec_valid_i && (!out_valid_q || pop_i);
  assign final_slot = (idx_q == rec_i.cnt - 2'd1);
  assign rec_pop_o  = load && final_slot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= final_slot ? 2'd0 : idx_q + 2'd1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_q <= rec_i.bytes[idx_q];
      out_last_q <= rec_i.last && final_slot;
    end
  end

  assign empty_o    = !out_valid_q;
  assign out_byte_o = out_byte_q;
  assign out_last_o = out_last_q;

endmodule

FILE: rtl/url_percent_decoder.sv
// channel   direction  beat taken when     fields
// input     in         push_i & !full_o    in_byte_i[7:0], in_last_i
// result    out        pop_i & !empty_o    out_byte_o[7:0], out_last_o
//
// one input beat per cycle while full_o is low; each beat turns into 0 to 3 result bytes
// the result side drains one byte per cycle from the record queue while pop_i takes
// each byte; an escape flush of 2 or 3 bytes leaves as that many separate result bytes
// full_o rises when the record queue (QueueDepth entries) is full
// reset clears the escape state, the queue and the output valid flag
// a result passes through the record queue and then the output register before it shows
module url_percent_decoder import upd_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  output logic       full_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       empty_o,
  input  logic       pop_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);

  upd_rec_t rec_in, rec_head;
  logic     rec_push, rec_pop;
  logic     q_full, q_empty;
  logic     accept;

  assign full_o = q_full;
  assign accept = push_i && !q_full;

  upd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .rec_push_o (rec_push),
    .rec_o      (rec_in)
  );

  upd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .wdata_i (rec_in),
    .pop_i   (rec_pop),
    .rdata_o (rec_head),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  upd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (!q_empty),
    .rec_i       (rec_head),
    .rec_pop_o   (rec_pop),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

endmodule

FILE: rtl/upd_checker.sv
module upd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push_i,
  input logic       full_o,
  input logic [7:0] in_byte_i,
  input logic       in_last_i,
  input logic       empty_o,
  input logic       pop_i,
  input logic [7:0] out_byte_o,
  input logic       out_last_o
);

  // a waiting result stays put until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(out_byte_o) && $stable(out_last_o)))
    else $error("result changed while stalled");

  // a full queue always has a byte staged at the output
  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !empty_o)
    else $error("queue full with nothing at the output");

  // an accepted input beat carries known data
  a_in_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !full_o) |-> !$isunknown({in_byte_i, in_last_i}))
    else $error("unknown data on an accepted input beat");

  // reset leaves the output side empty
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> empty_o)
    else $error("output not empty in reset");

endmodule

bind url_percent_decoder upd_checker u_upd_checker (.*);
